>>> hdl/frs_pkg.sv
// Shared types, constants and reply tables of the frame streams receiver.
`default_nettype none
package frs_pkg;

    // frame streams control types and field type
    localparam logic [31:0] CT_ACCEPT          = 32'd1;
    localparam logic [31:0] CT_START           = 32'd2;
    localparam logic [31:0] CT_STOP            = 32'd3;
    localparam logic [31:0] CT_READY           = 32'd4;
    localparam logic [31:0] CT_FINISH          = 32'd5;
    localparam logic [31:0] FIELD_CONTENT_TYPE = 32'd1;

    localparam logic [31:0] CONTROL_LEN_MAX = 32'd512;
    localparam logic [31:0] CONTENT_LEN_MAX = 32'd256;
    localparam logic [31:0] CSTR_LEN        = 32'd22;

    // ACCEPT reply: 20 header bytes then the content string
    localparam int ACCEPT_LEN = 42;
    localparam int FINISH_LEN = 12;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_STOPPED = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_CTRL_LEN    = 3'd1;
    localparam logic [2:0] ERR_BAD_FIELD   = 3'd2;
    localparam logic [2:0] ERR_CONTENT     = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED  = 3'd4;
    localparam logic [2:0] ERR_DATA_EARLY  = 3'd5;

    // events handed from parser to emitter
    localparam logic [2:0] EV_DATA   = 3'd0;
    localparam logic [2:0] EV_ERR    = 3'd1;
    localparam logic [2:0] EV_ACCEPT = 3'd2;
    localparam logic [2:0] EV_FINISH = 3'd3;
    localparam logic [2:0] EV_STOP   = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] err_code;
    } result_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
        logic [2:0] err;
    } ev_t;

    // "protobuf:dnstap.Dnstap"
    function automatic logic [7:0] content_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h70;
            5'd1:    c = 8'h72;
            5'd2:    c = 8'h6f;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h6f;
            5'd5:    c = 8'h62;
            5'd6:    c = 8'h75;
            5'd7:    c = 8'h66;
            5'd8:    c = 8'h3a;
            5'd9:    c = 8'h64;
            5'd10:   c = 8'h6e;
            5'd11:   c = 8'h73;
            5'd12:   c = 8'h74;
            5'd13:   c = 8'h61;
            5'd14:   c = 8'h70;
            5'd15:   c = 8'h2e;
            5'd16:   c = 8'h44;
            5'd17:   c = 8'h6e;
            5'd18:   c = 8'h73;
            5'd19:   c = 8'h74;
            5'd20:   c = 8'h61;
            5'd21:   c = 8'h70;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] accept_byte(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd20)
        begin
            case (idx)
                6'd7:    c = 8'd34;
                6'd11:   c = CT_ACCEPT[7:0];
                6'd15:   c = FIELD_CONTENT_TYPE[7:0];
                6'd19:   c = CSTR_LEN[7:0];
                default: c = 8'h00;
            endcase
        end
        else
        begin
            c = content_char(5'(idx - 6'd20));
        end
        return c;
    endfunction

    function automatic logic [7:0] finish_byte(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd7:    c = 8'd4;
            4'd11:   c = CT_FINISH[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/frs_chan_if.sv
// Valid/ready channel carrying one payload per beat.
`default_nettype none
interface frs_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/frs_parser.sv
// Byte-level frame parser and handshake state machine; at most one event per beat.
`default_nettype none
module frs_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    frs_chan_if.sink          rx,
    input  wire logic         take,
    output logic              ev_valid,
    output frs_pkg::ev_t      ev
);

    localparam logic [2:0] PH_WAIT       = 3'd0;
    localparam logic [2:0] PH_WAIT_START = 3'd1;
    localparam logic [2:0] PH_STARTED    = 3'd2;
    localparam logic [2:0] PH_STOPPED    = 3'd3;
    localparam logic [2:0] PH_HALTED     = 3'd4;

    localparam logic [2:0] ST_LEN        = 3'd0;
    localparam logic [2:0] ST_CTRL_LEN   = 3'd1;
    localparam logic [2:0] ST_CTRL_TYPE  = 3'd2;
    localparam logic [2:0] ST_FIELD_TYPE = 3'd3;
    localparam logic [2:0] ST_FIELD_LEN  = 3'd4;
    localparam logic [2:0] ST_CONTENT    = 3'd5;
    localparam logic [2:0] ST_SKIP       = 3'd6;
    localparam logic [2:0] ST_DATA       = 3'd7;

    // control type classes
    localparam logic [1:0] CK_OTHER = 2'd0;
    localparam logic [1:0] CK_READY = 2'd1;
    localparam logic [1:0] CK_START = 2'd2;
    localparam logic [1:0] CK_STOP  = 2'd3;

    logic [2:0]  phase_reg, phase_next;
    logic        bidir_reg, bidir_next;
    logic [2:0]  step_reg, step_next;
    logic [23:0] accum_reg, accum_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] rem_reg, rem_next;
    logic [1:0]  ckind_reg, ckind_next;
    logic        cmatch_reg, cmatch_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] word;
    logic [1:0]  biw_inc;
    logic [31:0] rem_dec;
    logic [1:0]  word_class;
    logic [1:0]  kind_sel;
    logic [4:0]  cidx;

    logic        do_ctl;
    logic        fail;
    logic [2:0]  fail_code;

    logic        ctl_fail;
    logic [2:0]  ctl_phase;
    logic        ctl_bidir;
    logic        ctl_ev_valid;
    logic [2:0]  ctl_ev_kind;

    assign rx.ready = take;
    assign accept   = rx.valid && take;
    assign b        = rx.data.rx_byte;
    assign word     = {accum_reg, b};
    assign biw_inc  = biw_reg + 2'd1;
    assign rem_dec  = (rem_reg != 32'd0) ? rem_reg - 32'd1 : 32'd0;
    // only meaningful while the content still matches, when at most 22 bytes remain
    assign cidx     = 5'(frs_pkg::CSTR_LEN[4:0] - rem_reg[4:0]);

    always_comb
    begin
        if (word == frs_pkg::CT_READY)
            word_class = CK_READY;
        else if (word == frs_pkg::CT_START)
            word_class = CK_START;
        else if (word == frs_pkg::CT_STOP)
            word_class = CK_STOP;
        else
            word_class = CK_OTHER;
    end

    // the type word itself is judged when a bare control frame ends on it
    assign kind_sel = (step_reg == ST_CTRL_TYPE) ? word_class : ckind_reg;

    // handshake decision at the end of a control frame
    always_comb
    begin
        ctl_fail     = 1'b0;
        ctl_phase    = phase_reg;
        ctl_bidir    = bidir_reg;
        ctl_ev_valid = 1'b0;
        ctl_ev_kind  = frs_pkg::EV_STOP;
        unique case (phase_reg)
            PH_WAIT:
            begin
                if (kind_sel == CK_READY)
                begin
                    ctl_bidir    = 1'b1;
                    ctl_ev_valid = 1'b1;
                    ctl_ev_kind  = frs_pkg::EV_ACCEPT;
                    ctl_phase    = PH_WAIT_START;
                end
                else if (kind_sel == CK_START)
                    ctl_phase = PH_STARTED;
                else
                    ctl_fail = 1'b1;
            end
            PH_WAIT_START:
            begin
                if (kind_sel == CK_START)
                    ctl_phase = PH_STARTED;
                else
                    ctl_fail = 1'b1;
            end
            default:
            begin
                if (kind_sel == CK_STOP)
                begin
                    ctl_ev_valid = 1'b1;
                    ctl_ev_kind  = bidir_reg ? frs_pkg::EV_FINISH : frs_pkg::EV_STOP;
                    ctl_phase    = PH_STOPPED;
                end
                else
                    ctl_fail = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bidir_next  = bidir_reg;
        step_next   = step_reg;
        accum_next  = accum_reg;
        biw_next    = biw_reg;
        rem_next    = rem_reg;
        ckind_next  = ckind_reg;
        cmatch_next = cmatch_reg;
        do_ctl      = 1'b0;
        fail        = 1'b0;
        fail_code   = frs_pkg::ERR_NONE;
        ev_valid    = 1'b0;
        ev          = '0;

        if (accept && (phase_reg < PH_STOPPED))
        begin
            case (step_reg)
                ST_DATA:
                begin
                    ev_valid = 1'b1;
                    ev.kind  = frs_pkg::EV_DATA;
                    ev.data  = b;
                    ev.last  = (rem_reg <= 32'd1);
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                        step_next = ST_LEN;
                end
                ST_CONTENT:
                begin
                    if (cmatch_reg && (b != frs_pkg::content_char(cidx)))
                        cmatch_next = 1'b0;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        if (!cmatch_next)
                        begin
                            fail      = 1'b1;
                            fail_code = frs_pkg::ERR_CONTENT;
                        end
                        else
                            do_ctl = 1'b1;
                    end
                end
                ST_SKIP:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                        do_ctl = 1'b1;
                end
                default:
                begin
                    accum_next = word[23:0];
                    biw_next   = biw_inc;
                    if (biw_inc == 2'd0)
                    begin
                        case (step_reg)
                            ST_LEN:
                            begin
                                if (word == 32'd0)
                                    step_next = ST_CTRL_LEN;
                                else if (phase_reg != PH_STARTED)
                                begin
                                    fail      = 1'b1;
                                    fail_code = frs_pkg::ERR_DATA_EARLY;
                                end
                                else
                                begin
                                    rem_next  = word;
                                    step_next = ST_DATA;
                                end
                            end
                            ST_CTRL_LEN:
                            begin
                                if ((word < 32'd4) || (word > frs_pkg::CONTROL_LEN_MAX))
                                begin
                                    fail      = 1'b1;
                                    fail_code = frs_pkg::ERR_CTRL_LEN;
                                end
                                else
                                begin
                                    rem_next  = word - 32'd4;
                                    step_next = ST_CTRL_TYPE;
                                end
                            end
                            ST_CTRL_TYPE:
                            begin
                                ckind_next = word_class;
                                if ((word_class == CK_READY) || (word_class == CK_START))
                                begin
                                    if (rem_reg < 32'd8)
                                    begin
                                        fail      = 1'b1;
                                        fail_code = frs_pkg::ERR_CTRL_LEN;
                                    end
                                    else
                                    begin
                                        rem_next  = rem_reg - 32'd8;
                                        step_next = ST_FIELD_TYPE;
                                    end
                                end
                                else if (rem_reg == 32'd0)
                                    do_ctl = 1'b1;
                                else
                                    step_next = ST_SKIP;
                            end
                            ST_FIELD_TYPE:
                            begin
                                cmatch_next = (word == frs_pkg::FIELD_CONTENT_TYPE);
                                step_next   = ST_FIELD_LEN;
                            end
                            ST_FIELD_LEN:
                            begin
                                if (!cmatch_reg || (word > frs_pkg::CONTENT_LEN_MAX)
                                    || (word != rem_reg))
                                begin
                                    fail      = 1'b1;
                                    fail_code = frs_pkg::ERR_BAD_FIELD;
                                end
                                else if (word == 32'd0)
                                begin
                                    // empty field can never match the content string
                                    cmatch_next = 1'b0;
                                    fail        = 1'b1;
                                    fail_code   = frs_pkg::ERR_CONTENT;
                                end
                                else
                                begin
                                    cmatch_next = (word == frs_pkg::CSTR_LEN);
                                    step_next   = ST_CONTENT;
                                end
                            end
                            default:
                            begin
                                step_next = ST_LEN;
                            end
                        endcase
                    end
                end
            endcase

            if (do_ctl && ctl_fail)
            begin
                fail      = 1'b1;
                fail_code = frs_pkg::ERR_UNEXPECTED;
            end

            if (fail)
            begin
                phase_next = PH_HALTED;
                step_next  = ST_LEN;
                biw_next   = 2'd0;
                ev_valid   = 1'b1;
                ev         = '0;
                ev.kind    = frs_pkg::EV_ERR;
                ev.err     = fail_code;
            end
            else if (do_ctl)
            begin
                step_next  = ST_LEN;
                biw_next   = 2'd0;
                phase_next = ctl_phase;
                bidir_next = ctl_bidir;
                ev_valid   = ctl_ev_valid;
                ev.kind    = ctl_ev_kind;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            bidir_reg  <= 1'b0;
            step_reg   <= ST_LEN;
            accum_reg  <= '0;
            biw_reg    <= 2'd0;
            rem_reg    <= '0;
            ckind_reg  <= CK_OTHER;
            cmatch_reg <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            bidir_reg  <= bidir_next;
            step_reg   <= step_next;
            accum_reg  <= accum_next;
            biw_reg    <= biw_next;
            rem_reg    <= rem_next;
            ckind_reg  <= ckind_next;
            cmatch_reg <= cmatch_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/frs_emitter.sv
// Event register and result register; expands reply events into byte bursts.
`default_nettype none
module frs_emitter (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          ev_valid,
    input  wire frs_pkg::ev_t  ev,
    output logic               take,
    frs_chan_if.source         result
);

    localparam logic [5:0] ACCEPT_END = 6'(frs_pkg::ACCEPT_LEN - 1);
    localparam logic [5:0] FINISH_END = 6'(frs_pkg::FINISH_LEN - 1);
    localparam logic [5:0] FINISH_STOP = 6'(frs_pkg::FINISH_LEN);

    logic              ev_valid_reg;
    frs_pkg::ev_t      ev_reg;
    logic [5:0]        idx_reg, idx_next;
    logic              res_valid_reg, res_valid_next;
    frs_pkg::result_t  res_reg, res_next;

    logic              out_load;
    logic              emit;
    logic              done;
    frs_pkg::result_t  elem;

    assign out_load = !res_valid_reg || result.ready;

    // beat of the pending event at position idx_reg
    always_comb
    begin
        elem = '0;
        emit = 1'b1;
        done = 1'b1;
        case (ev_reg.kind)
            frs_pkg::EV_DATA:
            begin
                elem.out_kind = frs_pkg::KIND_PAYLOAD;
                elem.out_byte = ev_reg.data;
                elem.out_last = ev_reg.last;
            end
            frs_pkg::EV_ERR:
            begin
                elem.out_kind = frs_pkg::KIND_ERROR;
                elem.err_code = ev_reg.err;
            end
            frs_pkg::EV_ACCEPT:
            begin
                elem.out_kind = frs_pkg::KIND_REPLY;
                elem.out_byte = frs_pkg::accept_byte(idx_reg);
                elem.out_last = (idx_reg == ACCEPT_END);
                done          = (idx_reg == ACCEPT_END);
            end
            frs_pkg::EV_FINISH:
            begin
                if (idx_reg < FINISH_STOP)
                begin
                    elem.out_kind = frs_pkg::KIND_REPLY;
                    elem.out_byte = frs_pkg::finish_byte(idx_reg[3:0]);
                    elem.out_last = (idx_reg == FINISH_END);
                    done          = 1'b0;
                end
                else
                    elem.out_kind = frs_pkg::KIND_STOPPED;
            end
            frs_pkg::EV_STOP:
            begin
                elem.out_kind = frs_pkg::KIND_STOPPED;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    logic fire;
    logic ev_done;

    assign fire    = ev_valid_reg && out_load;
    assign ev_done = fire && done;
    assign take    = !ev_valid_reg || ev_done;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        if (out_load)
        begin
            res_valid_next = fire && emit;
            res_next       = elem;
        end
        if (ev_done || (ev_valid && take))
            idx_next = 6'd0;
        else if (fire)
            idx_next = idx_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            idx_reg       <= 6'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_valid && take)
                ev_valid_reg <= 1'b1;
            else if (ev_done)
                ev_valid_reg <= 1'b0;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_valid && take)
            ev_reg <= ev;
        res_reg <= res_next;
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule
`default_nettype wire

>>> hdl/frame_streams_receiver_core.sv
// Frame streams receiver: byte parser, handshake machine and result emitter.
// A byte's event goes to the event register, then its result to the result register.
// Throughput: 1 byte per cycle while results are taken; the input is held while
// the 42-byte ACCEPT reply to READY, or a bidirectional STOP's FINISH reply, goes out.
// Reset (rst_n, async): parser back to waiting for READY or START, pending
// events and results dropped.
`default_nettype none
module frame_streams_receiver_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    frs_chan_if.sink   rx,
    frs_chan_if.source result
);

    logic          take;
    logic          ev_valid;
    frs_pkg::ev_t  ev;

    frs_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .take     (take),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    frs_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev       (ev),
        .take     (take),
        .result   (result)
    );

    // events are only raised on an accepted beat
    a_ev_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (rx.valid && rx.ready))
        else $error("event raised without an accepted beat");

    // error code set exactly on error results
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.data.out_kind == frs_pkg::KIND_ERROR)
                          == (result.data.err_code != frs_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // stop and error results carry no byte and no last flag
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && ((result.data.out_kind == frs_pkg::KIND_STOPPED)
                          || (result.data.out_kind == frs_pkg::KIND_ERROR)))
        |-> ((result.data.out_byte == 8'd0) && !result.data.out_last))
        else $error("status result carries payload");

endmodule
`default_nettype wire

>>> dv/frame_streams_receiver_core_test.sv
// Self-checking testbench of the frame streams receiver: byte stream in, result beats checked.
`default_nettype none
module frame_streams_receiver_core_test;
    import frs_pkg::*;

    localparam int STIM_ITEMS    = 450;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 100;
    localparam logic [8*22-1:0] CONTENT_TEXT = "protobuf:dnstap.Dnstap";

    typedef enum logic [2:0] {
        LINK_WAIT, LINK_WAIT_START, LINK_STARTED, LINK_STOPPED, LINK_HALTED
    } link_phase_e;

    typedef enum logic [3:0] {
        PS_LEN, PS_CTRL_LEN, PS_CTRL_TYPE, PS_FIELD_TYPE, PS_FIELD_LEN,
        PS_CONTENT, PS_SKIP, PS_DATA
    } parse_step_e;

    logic clk = 1'b0;
    logic rst_n;

    frs_chan_if #(.payload_t(rx_item_t)) rx_ch ();
    frs_chan_if #(.payload_t(result_t))  res_ch ();

    frame_streams_receiver_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    always #5 clk = ~clk;

    // stimulus and expectations
    rx_item_t stim_q[$];
    result_t  expected_results[$];
    int       mismatch_count = 0;
    int       rx_beats = 0;
    int       pressure_at = 0;
    bit       rx_taken = 1'b0;
    bit       res_taken = 1'b0;

    // predictor state
    link_phase_e rx_phase;
    logic        is_bidir;
    parse_step_e parse_at;
    logic [31:0] word_acc;
    logic [1:0]  word_bytes;
    logic [31:0] left_bytes;
    logic [31:0] ctrl_type;
    logic        field_ok;

    function automatic logic [7:0] dnstap_char(input logic [31:0] idx);
        if (idx > 32'd21)
            return 8'h00;
        return CONTENT_TEXT[8*(21-idx) +: 8];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] b,
                               input logic last, input logic [2:0] err);
        result_t r;
        r.out_kind = kind;
        r.out_byte = b;
        r.out_last = last;
        r.err_code = err;
        expected_results.push_back(r);
    endtask

    task automatic push_reply_word(input logic [31:0] w, input logic last_on_final);
        for (int i = 3; i >= 0; i--)
            push_result(KIND_REPLY, w[8*i +: 8], last_on_final && (i == 0), ERR_NONE);
    endtask

    task automatic halt_with(input logic [2:0] code);
        rx_phase   = LINK_HALTED;
        parse_at   = PS_LEN;
        word_bytes = 2'd0;
        push_result(KIND_ERROR, 8'h00, 1'b0, code);
    endtask

    // end of a complete control frame: judge it against the handshake
    task automatic close_control();
        parse_at   = PS_LEN;
        word_bytes = 2'd0;
        case (rx_phase)
            LINK_WAIT:
            begin
                if (ctrl_type == CT_READY)
                begin
                    is_bidir = 1'b1;
                    push_reply_word(32'd0, 1'b0);
                    push_reply_word(32'd34, 1'b0);
                    push_reply_word(CT_ACCEPT, 1'b0);
                    push_reply_word(FIELD_CONTENT_TYPE, 1'b0);
                    push_reply_word(CSTR_LEN, 1'b0);
                    for (int i = 0; i < 22; i++)
                        push_result(KIND_REPLY, dnstap_char(i), i == 21, ERR_NONE);
                    rx_phase = LINK_WAIT_START;
                end
                else if (ctrl_type == CT_START)
                    rx_phase = LINK_STARTED;
                else
                    halt_with(ERR_UNEXPECTED);
            end
            LINK_WAIT_START:
            begin
                if (ctrl_type != CT_START)
                    halt_with(ERR_UNEXPECTED);
                else
                    rx_phase = LINK_STARTED;
            end
            default:
            begin
                if (ctrl_type != CT_STOP)
                    halt_with(ERR_UNEXPECTED);
                else
                begin
                    if (is_bidir)
                    begin
                        push_reply_word(32'd0, 1'b0);
                        push_reply_word(32'd4, 1'b0);
                        push_reply_word(CT_FINISH, 1'b1);
                    end
                    push_result(KIND_STOPPED, 8'h00, 1'b0, ERR_NONE);
                    rx_phase = LINK_STOPPED;
                end
            end
        endcase
    endtask

    task automatic close_field();
        if (!field_ok)
            halt_with(ERR_CONTENT);
        else
            close_control();
    endtask

    task automatic take_word(input logic [31:0] w);
        case (parse_at)
            PS_LEN:
            begin
                if (w == 32'd0)
                    parse_at = PS_CTRL_LEN;
                else if (rx_phase != LINK_STARTED)
                    halt_with(ERR_DATA_EARLY);
                else
                begin
                    left_bytes = w;
                    parse_at   = PS_DATA;
                end
            end
            PS_CTRL_LEN:
            begin
                if (w < 32'd4 || w > CONTROL_LEN_MAX)
                    halt_with(ERR_CTRL_LEN);
                else
                begin
                    left_bytes = w - 32'd4;
                    parse_at   = PS_CTRL_TYPE;
                end
            end
            PS_CTRL_TYPE:
            begin
                ctrl_type = w;
                if (w == CT_READY || w == CT_START)
                begin
                    if (left_bytes < 32'd8)
                        halt_with(ERR_CTRL_LEN);
                    else
                    begin
                        left_bytes = left_bytes - 32'd8;
                        parse_at   = PS_FIELD_TYPE;
                    end
                end
                else if (left_bytes == 32'd0)
                    close_control();
                else
                    parse_at = PS_SKIP;
            end
            PS_FIELD_TYPE:
            begin
                field_ok = (w == FIELD_CONTENT_TYPE);
                parse_at = PS_FIELD_LEN;
            end
            PS_FIELD_LEN:
            begin
                if (!field_ok || w > CONTENT_LEN_MAX || w != left_bytes)
                    halt_with(ERR_BAD_FIELD);
                else
                begin
                    field_ok = (w == CSTR_LEN);
                    if (w == 32'd0)
                        close_field();
                    else
                        parse_at = PS_CONTENT;
                end
            end
            default:
                parse_at = PS_LEN;
        endcase
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        logic [31:0] idx;
        if (rx_phase == LINK_STOPPED || rx_phase == LINK_HALTED)
            return;
        case (parse_at)
            PS_DATA:
            begin
                push_result(KIND_PAYLOAD, b, left_bytes <= 32'd1, ERR_NONE);
                if (left_bytes > 32'd0)
                    left_bytes = left_bytes - 32'd1;
                if (left_bytes == 32'd0)
                    parse_at = PS_LEN;
            end
            PS_CONTENT:
            begin
                // index wraps when the field is longer than the string
                idx = CSTR_LEN - left_bytes;
                if (field_ok && (idx >= CSTR_LEN || b != dnstap_char(idx)))
                    field_ok = 1'b0;
                if (left_bytes > 32'd0)
                    left_bytes = left_bytes - 32'd1;
                if (left_bytes == 32'd0)
                    close_field();
            end
            PS_SKIP:
            begin
                if (left_bytes > 32'd0)
                    left_bytes = left_bytes - 32'd1;
                if (left_bytes == 32'd0)
                    close_control();
            end
            default:
            begin
                word_acc   = {word_acc[23:0], b};
                word_bytes = word_bytes + 2'd1;
                if (word_bytes == 2'd0)
                    take_word(word_acc);
            end
        endcase
    endtask

    // stream building
    task automatic send_byte(input logic [7:0] b);
        rx_item_t it;
        it.rx_byte = b;
        stim_q.push_back(it);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_data_frame(input int unsigned len);
        send_word(len);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_handshake(input logic [31:0] ctype);
        send_word(32'd0);
        send_word(32'd34);
        send_word(ctype);
        send_word(FIELD_CONTENT_TYPE);
        send_word(CSTR_LEN);
        for (int i = 0; i < 22; i++)
            send_byte(dnstap_char(i));
    endtask

    // one way of ending the started stream: clean stop or one protocol violation
    task automatic send_closing();
        int unsigned n;
        int unsigned k;
        logic [31:0] w;
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                send_word(32'd0);
                send_word(32'd4);
                send_word(CT_STOP);
            end
            3, 4:
            begin
                n = $urandom_range(1, 24);
                send_word(32'd0);
                send_word(32'd4 + n);
                send_word(CT_STOP);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            5:
            begin
                send_word(32'd0);
                send_word($urandom_range(0, 3));
            end
            6:
            begin
                send_word(32'd0);
                send_word($urandom_range(0, 1) ? 32'hFFFF_FFFF
                                               : CONTROL_LEN_MAX + $urandom_range(1, 600));
            end
            7:
            begin
                // handshake frame too short for its field
                send_word(32'd0);
                send_word(32'd4 + $urandom_range(0, 7));
                send_word($urandom_range(0, 1) ? CT_START : CT_READY);
            end
            8:
            begin
                send_word(32'd0);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        w = $urandom;
                        if (w == FIELD_CONTENT_TYPE)
                            w = 32'd2;
                        send_word(32'd34);
                        send_word(CT_START);
                        send_word(w);
                        send_word(CSTR_LEN);
                    end
                    1:
                    begin
                        send_word(32'd34);
                        send_word(CT_START);
                        send_word(FIELD_CONTENT_TYPE);
                        send_word(32'd21);
                    end
                    default:
                    begin
                        send_word(32'd312);
                        send_word(CT_START);
                        send_word(FIELD_CONTENT_TYPE);
                        send_word(32'd300);
                    end
                endcase
            end
            9:
            begin
                send_word(32'd0);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        k = $urandom_range(0, 21);
                        send_word(32'd34);
                        send_word(CT_START);
                        send_word(FIELD_CONTENT_TYPE);
                        send_word(CSTR_LEN);
                        for (int i = 0; i < 22; i++)
                            send_byte(i == k ? dnstap_char(i) ^ 8'($urandom_range(1, 255))
                                             : dnstap_char(i));
                    end
                    1:
                    begin
                        // empty content field
                        send_word(32'd12);
                        send_word(CT_START);
                        send_word(FIELD_CONTENT_TYPE);
                        send_word(32'd0);
                    end
                    2:
                    begin
                        send_word(32'd42);
                        send_word(CT_START);
                        send_word(FIELD_CONTENT_TYPE);
                        send_word(32'd30);
                        for (int i = 0; i < 22; i++)
                            send_byte(dnstap_char(i));
                        repeat (8) send_byte(8'($urandom_range(0, 255)));
                    end
                    default:
                    begin
                        send_word(32'd33);
                        send_word(CT_START);
                        send_word(FIELD_CONTENT_TYPE);
                        send_word(32'd21);
                        for (int i = 0; i < 21; i++)
                            send_byte(dnstap_char(i));
                    end
                endcase
            end
            10:
            begin
                // unknown or reply-only control type, extra bytes skipped first
                n = $urandom_range(0, 8);
                case ($urandom_range(0, 2))
                    0:       w = CT_ACCEPT;
                    1:       w = CT_FINISH;
                    default: w = $urandom;
                endcase
                if (w == CT_STOP || w == CT_READY || w == CT_START)
                    w = CT_FINISH;
                send_word(32'd0);
                send_word(32'd4 + n);
                send_word(w);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            default:
                send_handshake($urandom_range(0, 1) ? CT_START : CT_READY);
        endcase
    endtask

    // input driver
    int unsigned rx_gap = 0;
    bit          rx_burst = 1'b0;

    always @(negedge clk)
    begin : driver_p
        if (rst_n)
        begin
            if (rx_taken || !rx_ch.valid)
            begin
                rx_taken = 1'b0;
                if (rx_gap > 0)
                begin
                    rx_gap--;
                    rx_ch.valid <= 1'b0;
                end
                else if (stim_q.size() != 0)
                begin
                    rx_ch.data  <= stim_q.pop_front();
                    rx_ch.valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        rx_burst = !rx_burst;
                    rx_gap = rx_burst ? 0 : $urandom_range(0, 5);
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    int unsigned res_stall = 0;
    int unsigned hold_left = 0;
    bit          res_burst = 1'b0;
    bit          pressure_done = 1'b0;

    always @(negedge clk)
    begin : receiver_p
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    res_burst = !res_burst;
                res_stall = res_burst ? 0 : $urandom_range(0, 5);
            end
            if (!pressure_done && rx_beats >= pressure_at)
            begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (res_stall > 0)
            begin
                res_stall--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on input beats, check result beats in order
    always @(posedge clk)
    begin : monitor_p
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                predict_rx_byte(rx_ch.data.rx_byte);
                rx_taken = 1'b1;
                rx_beats++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                res_taken = 1'b1;
                got = res_ch.data;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected beat kind %0d byte %02h last %0d err %0d",
                                              got.out_kind, got.out_byte, got.out_last,
                                              got.err_code));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.out_kind != want.out_kind)
                        report_mismatch($sformatf("out_kind %0d, expected %0d",
                                                  got.out_kind, want.out_kind));
                    if (got.out_byte != want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  got.out_byte, want.out_byte));
                    if (got.out_last != want.out_last)
                        report_mismatch($sformatf("out_last %0d, expected %0d",
                                                  got.out_last, want.out_last));
                    if (got.err_code != want.err_code)
                        report_mismatch($sformatf("err_code %0d, expected %0d",
                                                  got.err_code, want.err_code));
                end
            end
        end
    end

    initial
    begin : main_p
        bit early;
        rst_n        = 1'b0;
        rx_ch.valid  = 1'b0;
        rx_ch.data   = '0;
        res_ch.ready = 1'b0;

        rx_phase   = LINK_WAIT;
        is_bidir   = 1'b0;
        parse_at   = PS_LEN;
        word_acc   = 32'd0;
        word_bytes = 2'd0;
        left_bytes = 32'd0;
        ctrl_type  = 32'd0;
        field_ok   = 1'b1;

        early = ($urandom_range(0, 9) == 0);
        if (early)
        begin
            // violations before the stream is started
            case ($urandom_range(0, 4))
                0: send_data_frame($urandom_range(1, 8));
                1:
                begin
                    send_handshake(CT_READY);
                    send_data_frame(3);
                end
                2:
                begin
                    send_word(32'd0);
                    send_word(32'd4);
                    send_word(CT_STOP);
                end
                3:
                begin
                    send_handshake(CT_READY);
                    send_word(32'd0);
                    send_word(32'd4);
                    send_word(CT_STOP);
                end
                default:
                begin
                    send_handshake(CT_READY);
                    send_handshake(CT_READY);
                end
            endcase
        end
        else
        begin
            if ($urandom_range(0, 1))
                send_handshake(CT_READY);
            send_handshake(CT_START);
            send_word(32'd1);
            send_byte(8'h00);
            send_word(32'd1);
            send_byte(8'hFF);
            send_word(32'd2);
            send_byte(8'hA5);
            send_byte(8'h5A);
            while (stim_q.size() < STIM_ITEMS)
                send_data_frame(($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                            : $urandom_range(1, 12));
            send_closing();
        end
        // bytes after stop or error must be swallowed
        repeat (32) send_byte(8'($urandom_range(0, 255)));
        pressure_at = stim_q.size() / 3;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || rx_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      expected_results.size()));

        if (mismatch_count == 0)
            $display("frame_streams_receiver_core verification clean");
        else
            $display("frame_streams_receiver_core verification failed");
        $finish;
    end

    initial
    begin : watchdog_p
        #1000000;
        $display("frame_streams_receiver_core verification failed");
        $finish;
    end

endmodule
`default_nettype wire
